[rtl/core/osa_pkg.sv]
package osa_pkg;

	localparam int MAX_LEN = 256;
	// index 0..MAX_LEN
	localparam int IDX_W   = $clog2(MAX_LEN + 1);
	localparam int FS_AW   = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
	// cell values reach MAX_LEN + 1 before the minimum
	localparam int VAL_W   = $clog2(MAX_LEN + 2);
	localparam int CUT_W   = 9;
	localparam int DIST_W  = 9;
	localparam int CMP_W   = (VAL_W > CUT_W) ? VAL_W : CUT_W;
	localparam int SYM_W   = 8;
	localparam int ACT_W   = 2;

	typedef enum logic [ACT_W-1:0] {
		ACT_LOAD   = 2'd0,
		ACT_PROC   = 2'd1,
		ACT_FINISH = 2'd2,
		ACT_NONE   = 2'd3
	} action_t;

	typedef enum logic {
		ST_IDLE,
		ST_ROW
	} state_t;

	typedef enum logic {
		PH_LOAD,
		PH_PROC
	} phase_t;

	typedef enum logic [1:0] {
		BANK0 = 2'd0,
		BANK1 = 2'd1,
		BANK2 = 2'd2,
		BANK_X = 2'd3
	} bank_t;

endpackage

[rtl/core/osa_edit_distance.sv]
// channel | dir | tdata                       | tuser
// s_axis  | in  | [7:0] symbol                | [1:0] action
// m_axis  | out | [8:0] distance              | [0] cut_off, [1] length_error
// cfg     | in  | cfg_wdata[8:0] distance_cutoff, written when cfg_wen is high
//
// A second-string byte is worked one cell per cycle through the row banks (one read
// port each); the bank and first-string reads are registered before each cell is entered.
// Reset clears all control state; the memories are not cleared.
// s_tready drops while a row is worked and while a result waits on m_axis.
module osa_edit_distance (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_wen,
	input  logic [osa_pkg::CUT_W-1:0]   cfg_wdata,
	input  logic                        s_tvalid,
	output logic                        s_tready,
	input  logic [7:0]                  s_tdata,   // symbol
	input  logic [osa_pkg::ACT_W-1:0]   s_tuser,   // action
	output logic                        m_tvalid,
	input  logic                        m_tready,
	output logic [15:0]                 m_tdata,   // distance, zero padded
	output logic [1:0]                  m_tuser    // cut_off, length_error
);
	import osa_pkg::*;

	state_t state_q, state_d;
	phase_t phase_q;

	logic [CUT_W-1:0] cutoff_q;
	logic [IDX_W-1:0] len_q;
	logic [IDX_W-1:0] count_q;
	logic [SYM_W-1:0] last_b_q;
	logic             exceeded_q;
	logic             overflow_q;
	bank_t            cur_q;
	bank_t            prev_sel, twob_sel;

	logic             in_acc;
	logic             proc_go;
	logic             load_go;
	logic             fin_go;
	action_t          act;

	logic [SYM_W-1:0] c2_q;
	logic [IDX_W-1:0] iss_j_q;
	logic             iss_on_q;
	logic             v_s1;
	logic [IDX_W-1:0] j_s1;

	logic [VAL_W-1:0] cell_q;
	logic [VAL_W-1:0] prev_jm1_q;
	logic [SYM_W-1:0] prev_c1_q;
	logic [VAL_W-1:0] rmin_q;

	logic [SYM_W-1:0] fs_mem [0:MAX_LEN-1];
	logic [SYM_W-1:0] fs_rd;
	logic [VAL_W-1:0] bank_rd [0:2];

	logic [VAL_W-1:0] prev_j, twob_jm2;
	logic [VAL_W-1:0] ins, del, sub, tra, m1, m2, cell_new;
	logic [VAL_W-1:0] rmin_new;
	logic             row_end;
	logic             first_row, second_row;

	logic             mv_q;
	logic [DIST_W-1:0] dist_q;
	logic             cut_q, lerr_q;
	logic [IDX_W-1:0] diff;
	logic [VAL_W-1:0] dist_raw;
	logic             cut_fin;

	assign act = action_t'(s_tuser);

	always_comb begin
		case (cur_q)
			BANK0: begin prev_sel = BANK2; twob_sel = BANK1; end
			BANK1: begin prev_sel = BANK0; twob_sel = BANK2; end
			BANK2: begin prev_sel = BANK1; twob_sel = BANK0; end
			default: begin prev_sel = BANK_X; twob_sel = BANK_X; end
		endcase
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (proc_go)
					state_d = ST_ROW;
			end
			ST_ROW: begin
				if (row_end)
					state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// handshake and strobes
	always_comb begin
		s_tready = (state_q == ST_IDLE) && (!mv_q || m_tready);
		in_acc   = s_tvalid && s_tready;
		proc_go  = in_acc && (act == ACT_PROC) && (count_q < IDX_W'(MAX_LEN));
		load_go  = in_acc && (act == ACT_LOAD) && (phase_q == PH_LOAD)
			&& (len_q < IDX_W'(MAX_LEN));
		fin_go   = in_acc && (act == ACT_FINISH);
	end

	// cell datapath; rows 0 and column values of the identity row are implied
	always_comb begin
		first_row  = (count_q == IDX_W'(1));
		second_row = (count_q == IDX_W'(2));
		prev_j   = first_row  ? VAL_W'(j_s1) : bank_rd[prev_sel];
		twob_jm2 = second_row ? (VAL_W'(j_s1) - VAL_W'(2)) : bank_rd[twob_sel];
		ins = prev_j + VAL_W'(1);
		del = cell_q + VAL_W'(1);
		sub = prev_jm1_q + ((fs_rd != c2_q) ? VAL_W'(1) : VAL_W'(0));
		if ((j_s1 > IDX_W'(1)) && (count_q > IDX_W'(1)) && (prev_c1_q == c2_q)
				&& (last_b_q == fs_rd))
			tra = twob_jm2 + VAL_W'(1);
		else
			tra = ins;
		m1 = (ins < del) ? ins : del;
		m2 = (sub < tra) ? sub : tra;
		if (j_s1 == '0)
			cell_new = VAL_W'(count_q);
		else
			cell_new = (m1 < m2) ? m1 : m2;
		rmin_new = ((j_s1 != '0) && (cell_new < rmin_q)) ? cell_new : rmin_q;
		row_end  = v_s1 && (j_s1 == len_q);
	end

	// finish
	always_comb begin
		dist_raw = (phase_q == PH_LOAD) ? VAL_W'(len_q) : cell_q;
		diff     = (len_q > count_q) ? (len_q - count_q) : (count_q - len_q);
		cut_fin  = exceeded_q || ((cutoff_q != '0) && (CMP_W'(diff) > CMP_W'(cutoff_q)));
	end

	always_ff @(posedge clk) begin
		if (load_go)
			fs_mem[len_q[FS_AW-1:0]] <= s_tdata;
		fs_rd <= fs_mem[FS_AW'(iss_j_q - IDX_W'(1))];
	end

	for (genvar b = 0; b < 3; b++) begin : g_bank
		logic [VAL_W-1:0] mem [0:MAX_LEN];
		logic [IDX_W-1:0] raddr;

		assign raddr = (bank_t'(b) == prev_sel) ? iss_j_q : (iss_j_q - IDX_W'(2));

		always_ff @(posedge clk) begin
			if (v_s1 && (bank_t'(b) == cur_q))
				mem[j_s1] <= cell_new;
			bank_rd[b] <= mem[raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			phase_q    <= PH_LOAD;
			cutoff_q   <= '0;
			len_q      <= '0;
			count_q    <= '0;
			last_b_q   <= '0;
			exceeded_q <= 1'b0;
			overflow_q <= 1'b0;
			cur_q      <= BANK0;
			iss_on_q   <= 1'b0;
			iss_j_q    <= '0;
			v_s1       <= 1'b0;
			mv_q       <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_wen)
				cutoff_q <= cfg_wdata;

			if (mv_q && m_tready)
				mv_q <= 1'b0;

			if (in_acc) begin
				case (act)
					ACT_LOAD: begin
						if (phase_q == PH_LOAD) begin
							if (len_q < IDX_W'(MAX_LEN))
								len_q <= len_q + IDX_W'(1);
							else
								overflow_q <= 1'b1;
						end
					end
					ACT_PROC: begin
						phase_q <= PH_PROC;
						if (proc_go) begin
							count_q  <= count_q + IDX_W'(1);
							cur_q    <= (cur_q == BANK2) ? BANK0 : bank_t'(cur_q + 2'd1);
							iss_on_q <= 1'b1;
							iss_j_q  <= '0;
						end else begin
							overflow_q <= 1'b1;
						end
					end
					ACT_FINISH: begin
						mv_q       <= 1'b1;
						phase_q    <= PH_LOAD;
						len_q      <= '0;
						count_q    <= '0;
						last_b_q   <= '0;
						exceeded_q <= 1'b0;
						overflow_q <= 1'b0;
					end
					default: ;
				endcase
			end

			if (iss_on_q) begin
				iss_j_q <= iss_j_q + IDX_W'(1);
				if (iss_j_q == len_q)
					iss_on_q <= 1'b0;
			end
			v_s1 <= iss_on_q;

			if (row_end) begin
				last_b_q <= c2_q;
				if ((cutoff_q != '0) && (CMP_W'(rmin_new) > CMP_W'(cutoff_q)))
					exceeded_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (proc_go) begin
			c2_q   <= s_tdata;
			rmin_q <= VAL_W'(len_q);
		end
		j_s1 <= iss_j_q;
		if (v_s1) begin
			cell_q     <= cell_new;
			prev_jm1_q <= prev_j;
			prev_c1_q  <= fs_rd;
			rmin_q     <= rmin_new;
		end
		if (fin_go) begin
			dist_q <= cut_fin ? (cutoff_q + CUT_W'(1)) : DIST_W'(dist_raw);
			cut_q  <= cut_fin;
			lerr_q <= overflow_q;
		end
	end

	assign m_tvalid = mv_q;
	assign m_tdata  = 16'(dist_q);
	assign m_tuser  = {lerr_q, cut_q};

endmodule

[rtl/core/osa_checker.sv]
module osa_checker (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      s_tvalid,
	input logic                      s_tready,
	input logic [osa_pkg::ACT_W-1:0] s_tuser,
	input logic                      m_tvalid,
	input logic                      m_tready,
	input logic [15:0]               m_tdata,
	input logic [1:0]                m_tuser
);
	import osa_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

	a_fin_gives_item: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && (s_tuser == ACT_FINISH) |=> m_tvalid)
		else $error("finish gave no result");

	a_item_from_fin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(s_tvalid && s_tready && (s_tuser == ACT_FINISH)))
		else $error("result without finish");

	a_no_take_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |-> !s_tready)
		else $error("input taken while result blocked");

endmodule

bind osa_edit_distance osa_checker u_osa_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tuser  (s_tuser),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);

[verif/osa_edit_distance_tb.sv]
module osa_edit_distance_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import osa_pkg::*;

	localparam int unsigned SETTLE_CYCLES = MAX_LEN + 44;
	localparam int unsigned QUIET_LIMIT   = 4000;
	localparam int unsigned ITEM_TARGET   = 1900;
	localparam int unsigned N_PHASES      = 8;

	typedef struct {
		action_t     act;
		logic [7:0]  sym;
		int unsigned gap;
	} byte_cmd_t;

	typedef struct {
		logic [DIST_W-1:0] distance;
		logic              cut;
		logic              lerr;
	} osa_result_t;

	logic              clk       = 1'b0;
	logic              arst_n    = 1'b0;
	logic              cfg_wen   = 1'b0;
	logic [CUT_W-1:0]  cfg_wdata = '0;
	logic              s_tvalid  = 1'b0;
	logic              s_tready;
	logic [7:0]        s_tdata   = '0;	// symbol
	logic [ACT_W-1:0]  s_tuser   = '0;	// action
	logic              m_tvalid;
	logic              m_tready  = 1'b0;
	logic [15:0]       m_tdata;	// distance, zero padded
	logic [1:0]        m_tuser;	// cut_off, length_error

	// alignment predictor state
	logic [CUT_W-1:0]  cutoff_now = '0;
	logic [7:0]        a_str [MAX_LEN];
	int unsigned       row_c [MAX_LEN+1];
	int unsigned       row_p [MAX_LEN+1];
	int unsigned       row_pp [MAX_LEN+1];
	int unsigned       a_len  = 0;
	int unsigned       b_cnt  = 0;
	logic [7:0]        b_last = '0;
	logic              over_cut = 1'b0;
	logic              too_long = 1'b0;
	phase_t            pair_ph  = PH_LOAD;

	byte_cmd_t         cmd_q [$];
	osa_result_t       due_results [$];
	int unsigned       n_items = 0;
	int unsigned       errs    = 0;
	bit                idle_on = 1'b0;
	int unsigned       gap_cnt;
	int unsigned       hold_cnt;
	int unsigned       quiet = 0;

	osa_edit_distance i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wen   (cfg_wen),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

	always #1 clk = ~clk;

	function automatic int unsigned pause_len();
		return idle_on ? $urandom_range(0, 17) : 0;
	endfunction

	function automatic int unsigned lesser(int unsigned x, int unsigned y);
		return (x < y) ? x : y;
	endfunction

	task automatic flag_error(string what, int got, int want);
		$display("mismatch %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
		errs++;
	endtask

	task automatic align_step(action_t act, logic [7:0] sym);
		int unsigned j, rmin, ins, del, sub, tra, diff;
		logic [7:0] prev_a;
		osa_result_t r;
		case (act)
		ACT_LOAD: begin
			if (pair_ph == PH_LOAD) begin
				if (a_len >= MAX_LEN) begin
					too_long = 1'b1;
				end else begin
					a_str[a_len] = sym;
					a_len++;
				end
			end
		end
		ACT_PROC: begin
			if (pair_ph == PH_LOAD) begin
				for (j = 0; j <= a_len; j++)
					row_c[j] = j;
				pair_ph = PH_PROC;
			end
			if (b_cnt >= MAX_LEN) begin
				too_long = 1'b1;
			end else begin
				b_cnt++;
				row_pp = row_p;
				row_p = row_c;
				row_c[0] = b_cnt;
				rmin = a_len;
				prev_a = '0;
				for (j = 1; j <= a_len; j++) begin
					ins = row_p[j] + 1;
					del = row_c[j-1] + 1;
					sub = row_p[j-1] + ((a_str[j-1] != sym) ? 1 : 0);
					tra = ins;
					if (j > 1 && b_cnt > 1 && prev_a == sym && b_last == a_str[j-1])
						tra = row_pp[j-2] + 1;
					prev_a = a_str[j-1];
					row_c[j] = lesser(lesser(ins, del), lesser(sub, tra));
					rmin = lesser(rmin, row_c[j]);
				end
				if (cutoff_now != 0 && rmin > cutoff_now)
					over_cut = 1'b1;
				b_last = sym;
			end
		end
		ACT_FINISH: begin
			r.cut = over_cut;
			r.distance = (pair_ph == PH_LOAD) ? a_len[DIST_W-1:0]
				: row_c[a_len][DIST_W-1:0];
			diff = (a_len > b_cnt) ? a_len - b_cnt : b_cnt - a_len;
			if (cutoff_now != 0 && diff > cutoff_now)
				r.cut = 1'b1;
			if (r.cut)
				r.distance = cutoff_now + 9'd1;
			r.lerr = too_long;
			due_results.insert(due_results.size(), r);
			a_len = 0;
			b_cnt = 0;
			b_last = '0;
			over_cut = 1'b0;
			too_long = 1'b0;
			pair_ph = PH_LOAD;
		end
		default: begin
		end
		endcase
	endtask

	// sender
	always @(posedge clk or negedge arst_n) begin
		byte_cmd_t cmd;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			gap_cnt = 0;
		end else begin
			if (s_tvalid && s_tready)
				align_step(action_t'(s_tuser), s_tdata);
			if (!s_tvalid || s_tready) begin
				if (cmd_q.size() != 0 && gap_cnt >= cmd_q[0].gap) begin
					cmd = cmd_q.pop_front();
					s_tvalid <= 1'b1;
					s_tuser <= cmd.act;
					s_tdata <= cmd.sym;
					gap_cnt = 0;
				end else begin
					s_tvalid <= 1'b0;
					if (cmd_q.size() != 0)
						gap_cnt++;
				end
			end
		end
	end

	// receiver and checker
	always @(posedge clk or negedge arst_n) begin
		osa_result_t want;
		logic rdy_next;
		if (!arst_n) begin
			m_tready <= 1'b0;
			hold_cnt = 0;
		end else begin
			rdy_next = m_tready;
			if (m_tvalid && m_tready) begin
				if (due_results.size() == 0) begin
					flag_error("result with nothing due, distance",
						int'(m_tdata[DIST_W-1:0]), 0);
				end else begin
					want = due_results.pop_front();
					if (m_tdata[DIST_W-1:0] !== want.distance)
						flag_error("distance", int'(m_tdata[DIST_W-1:0]),
							int'(want.distance));
					if (m_tuser[0] !== want.cut)
						flag_error("cut_off", int'(m_tuser[0]), int'(want.cut));
					if (m_tuser[1] !== want.lerr)
						flag_error("length_error", int'(m_tuser[1]), int'(want.lerr));
				end
				hold_cnt = pause_len();
				rdy_next = (hold_cnt == 0);
			end else if (!m_tready) begin
				if (hold_cnt <= 1)
					rdy_next = 1'b1;
				if (hold_cnt != 0)
					hold_cnt--;
			end
			m_tready <= rdy_next;
		end
	end

	// watchdog on cycles with no item moving
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_wen) begin
			quiet <= 0;
		end else if (quiet >= QUIET_LIMIT) begin
			$display("FAIL");
			$finish;
		end else begin
			quiet <= quiet + 1;
		end
	end

	task automatic push_cmd(action_t act, logic [7:0] sym);
		byte_cmd_t c;
		c.act = act;
		c.sym = sym;
		c.gap = pause_len();
		cmd_q.insert(cmd_q.size(), c);
		if (act != ACT_NONE)
			n_items++;
	endtask

	task automatic wait_idle();
		do
			@(negedge clk);
		while (cmd_q.size() != 0 || s_tvalid || due_results.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_cutoff(logic [CUT_W-1:0] v);
		@(posedge clk);
		cfg_wen <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_wen <= 1'b0;
		cutoff_now = v;
	endtask

	function automatic logic [7:0] pick_sym(int unsigned style);
		// narrow alphabet gives matches and transpositions
		if (style == 0)
			return 8'($urandom_range(0, 255));
		return 8'($urandom_range(0, 3) * 32'h55);
	endfunction

	// style 0: random bytes, 1: narrow alphabet, 2: second string edited from the first
	task automatic run_pair(int unsigned la, int unsigned lb, int unsigned style);
		logic [7:0] sa [$];
		logic [7:0] sb [$];
		logic [7:0] t;
		int unsigned k;
		for (k = 0; k < la; k++)
			sa.insert(sa.size(), pick_sym(style));
		if (style == 2) begin
			sb = sa;
			repeat ($urandom_range(0, 3)) begin
				k = (sb.size() > 1) ? $urandom_range(0, sb.size() - 2) : 0;
				case ($urandom_range(0, 3))
				0: begin
					if (sb.size() > 1) begin
						t = sb[k];
						sb[k] = sb[k+1];
						sb[k+1] = t;
					end
				end
				1: begin
					if (sb.size() != 0)
						sb[k] = pick_sym(1);
				end
				2: begin
					if (sb.size() != 0)
						sb.delete(k);
				end
				default: begin
					sb.insert(k, pick_sym(1));
				end
				endcase
			end
		end else begin
			for (k = 0; k < lb; k++)
				sb.insert(sb.size(), pick_sym(style));
		end
		foreach (sa[i]) begin
			if ($urandom_range(0, 39) == 0)
				push_cmd(ACT_NONE, 8'($urandom_range(0, 255)));
			push_cmd(ACT_LOAD, sa[i]);
		end
		foreach (sb[i]) begin
			push_cmd(ACT_PROC, sb[i]);
			if ($urandom_range(0, 29) == 0)
				push_cmd(ACT_LOAD, 8'($urandom_range(0, 255)));
			if ($urandom_range(0, 39) == 0)
				push_cmd(ACT_NONE, 8'($urandom_range(0, 255)));
		end
		push_cmd(ACT_FINISH, 8'($urandom_range(0, 255)));
	endtask

	initial begin
		logic [CUT_W-1:0] cut_plan [N_PHASES];
		int unsigned p, hi;
		cut_plan = '{9'd0, 9'd256, 9'd511, 9'd2, 9'd1, 9'd255, 9'd4, 9'd0};
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		set_cutoff(9'd0);
		idle_on = 1'b1;

		// empty pair
		push_cmd(ACT_FINISH, 8'hff);
		// transposition, stray load after processing, unused action
		push_cmd(ACT_LOAD, 8'h00);
		push_cmd(ACT_LOAD, 8'hff);
		push_cmd(ACT_PROC, 8'hff);
		push_cmd(ACT_LOAD, 8'h3c);
		push_cmd(ACT_PROC, 8'h00);
		push_cmd(ACT_NONE, 8'ha5);
		push_cmd(ACT_FINISH, 8'h00);
		// empty second string
		push_cmd(ACT_LOAD, 8'h80);
		push_cmd(ACT_LOAD, 8'h7f);
		push_cmd(ACT_LOAD, 8'h01);
		push_cmd(ACT_FINISH, 8'h5a);
		wait_idle();
		set_cutoff(9'd1);
		// row minimum beyond the cutoff
		push_cmd(ACT_LOAD, 8'h61);
		push_cmd(ACT_LOAD, 8'h62);
		push_cmd(ACT_PROC, 8'h78);
		push_cmd(ACT_PROC, 8'h79);
		push_cmd(ACT_FINISH, 8'h00);
		// empty first string, only the length check cuts
		push_cmd(ACT_PROC, 8'h11);
		push_cmd(ACT_PROC, 8'h22);
		push_cmd(ACT_PROC, 8'h33);
		push_cmd(ACT_FINISH, 8'h00);
		// cutoff changed mid-pair: sticky flag survives, final value used
		push_cmd(ACT_LOAD, 8'h61);
		push_cmd(ACT_LOAD, 8'h62);
		push_cmd(ACT_PROC, 8'h78);
		push_cmd(ACT_PROC, 8'h79);
		wait_idle();
		set_cutoff(9'd0);
		push_cmd(ACT_FINISH, 8'h00);

		n_items = 0;
		for (p = 0; p < N_PHASES; p++) begin
			wait_idle();
			if (p == N_PHASES - 1)
				cut_plan[p] = 9'($urandom_range(3, 12));
			set_cutoff(cut_plan[p]);
			idle_on = 1'b1;
			// overlong first string, maximum distance
			if (p == 0)
				run_pair(MAX_LEN + 2, 0, 0);
			// overlong second string
			if (p == 5)
				run_pair(1, MAX_LEN + 2, 0);
			while (n_items < (p + 1) * ITEM_TARGET / N_PHASES) begin
				idle_on = ($urandom_range(0, 3) != 0);
				hi = $urandom_range(0, 19);
				hi = (hi < 14) ? 8 : (hi < 19) ? 24 : 64;
				run_pair($urandom_range(0, hi), $urandom_range(0, hi), $urandom_range(0, 2));
			end
		end
		wait_idle();
		if (due_results.size() != 0)
			flag_error("results still due at end", 0, due_results.size());
		if (errs == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
